### hdl/region_majority_label_vote_defines.svh
// assertion macros shared by the checker of the region majority vote block
`ifndef REGION_MAJORITY_LABEL_VOTE_DEFINES_SVH
`define REGION_MAJORITY_LABEL_VOTE_DEFINES_SVH

// clocked assertion, switched off while reset is held
`define RMLV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// clocked assertion that also holds during reset
`define RMLV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);

`endif

### hdl/rmlv_pkg.sv
// shared types and constants of the region majority vote block
package rmlv_pkg;

    // one request: add a voxel or query a cell
    typedef struct packed {
        logic       func;
        logic [7:0] cell_index;
        logic [3:0] voxel_label;
    } req_t;

    // one answer to a query
    typedef struct packed {
        logic [7:0]  queried_cell;
        logic [3:0]  majority_label;
        logic [23:0] majority_count;
        logic        cell_empty;
    } rsp_t;

    // sequencer states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ADD_WR,
        ST_SCAN,
        ST_DONE
    } seq_state_t;

    // control of the shared compare unit
    typedef struct packed {
        logic start;
        logic step;
        logic vote;
    } alu_ctl_t;

    // request function codes
    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // register index (address bit 2)
    localparam logic REG_LABELS_IN_USE = 1'b0;

    localparam logic [4:0]  LABELS_RESET  = 5'd16;
    localparam logic [23:0] OUT_COUNT_MAX = 24'hFF_FFFF;

endpackage

### hdl/rmlv_hist_mem.sv
// histogram counter memory: one write port, one registered read port
module rmlv_hist_mem #(
    parameter int DEPTH  = 4096,
    parameter int ADDR_W = 12,
    parameter int DATA_W = 24
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem_reg [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem_reg[raddr];
    end

endmodule

### hdl/rmlv_vote_alu.sv
// shared compare and increment unit: running majority over one cell
module rmlv_vote_alu #(
    parameter int LBL_W      = 4,
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  rmlv_pkg::alu_ctl_t    ctl,
    input  logic [LBL_W-1:0]      idx,
    input  logic [COUNT_BITS-1:0] data,
    output logic [COUNT_BITS-1:0] inc_data,
    output logic [LBL_W-1:0]      best_lbl,
    output logic [COUNT_BITS-1:0] best_cnt,
    output logic                  empty
);

    logic [LBL_W-1:0]      best_lbl_reg;
    logic [COUNT_BITS-1:0] best_cnt_reg;
    logic                  empty_reg;
    logic                  win;

    // saturating increment for adds
    assign inc_data = (data == '1) ? data : data + COUNT_BITS'(1);

    // strictly greater keeps the smallest label on ties
    assign win = ctl.vote && (data > best_cnt_reg);

    // running best and empty flag
    always_ff @(posedge aclk) begin
        if (ctl.start) begin
            best_lbl_reg <= '0;
            best_cnt_reg <= '0;
            empty_reg    <= 1'b1;
        end else if (ctl.step) begin
            if (data != '0) begin
                empty_reg <= 1'b0;
            end
            if (win) begin
                best_lbl_reg <= idx;
                best_cnt_reg <= data;
            end
        end
    end

    assign best_lbl = best_lbl_reg;
    assign best_cnt = best_cnt_reg;
    assign empty    = empty_reg;

endmodule

### hdl/rmlv_seq.sv
// sequencer: clearing sweep, add read-modify-write, query scan and clear
module rmlv_seq #(
    parameter int NUM_CELLS  = 256,
    parameter int NUM_LABELS = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  rmlv_pkg::req_t        s_req,
    output logic                  s_ready,
    input  logic [4:0]            lbl_use,
    input  logic [COUNT_BITS-1:0] inc_data,
    input  logic                  out_free,
    output logic                  out_load,
    output logic [7:0]            qcell,
    output rmlv_pkg::alu_ctl_t    alu_ctl,
    output logic [$clog2(NUM_LABELS)-1:0] alu_idx,
    output logic                  mem_we,
    output logic [$clog2(NUM_CELLS)+$clog2(NUM_LABELS)-1:0] mem_waddr,
    output logic [COUNT_BITS-1:0] mem_wdata,
    output logic [$clog2(NUM_CELLS)+$clog2(NUM_LABELS)-1:0] mem_raddr
);

    localparam int CELL_W    = $clog2(NUM_CELLS);
    localparam int LBL_W     = $clog2(NUM_LABELS);
    localparam int ADDR_W    = CELL_W + LBL_W;
    localparam int MEM_DEPTH = NUM_CELLS * (1 << LBL_W);

    rmlv_pkg::seq_state_t state_reg, state_next;
    rmlv_pkg::req_t       req_reg;
    logic                 ok_reg;
    logic [LBL_W-1:0]     idx_reg;
    logic [ADDR_W-1:0]    sweep_reg;

    logic accept;
    logic cell_ok;
    logic lbl_ok;
    logic is_query;
    logic scan_last;
    logic sweep_last;

    assign s_ready    = (state_reg == rmlv_pkg::ST_IDLE);
    assign accept     = s_valid && s_ready;
    assign is_query   = (s_req.func == rmlv_pkg::FUNC_QUERY);
    assign cell_ok    = 32'(s_req.cell_index) < NUM_CELLS;
    assign lbl_ok     = 32'(s_req.voxel_label) < NUM_LABELS;
    assign scan_last  = (idx_reg == LBL_W'(NUM_LABELS - 1));
    assign sweep_last = (sweep_reg == ADDR_W'(MEM_DEPTH - 1));
    assign qcell      = req_reg.cell_index;
    assign alu_idx    = idx_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            rmlv_pkg::ST_CLEAR: begin
                if (sweep_last) begin
                    state_next = rmlv_pkg::ST_IDLE;
                end
            end
            rmlv_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = is_query ? rmlv_pkg::ST_SCAN : rmlv_pkg::ST_ADD_WR;
                end
            end
            rmlv_pkg::ST_ADD_WR: begin
                state_next = rmlv_pkg::ST_IDLE;
            end
            rmlv_pkg::ST_SCAN: begin
                if (scan_last) begin
                    state_next = rmlv_pkg::ST_DONE;
                end
            end
            rmlv_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = rmlv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = rmlv_pkg::ST_CLEAR;
            end
        endcase
    end

    // outputs: memory ports, compare unit control, result load
    always_comb begin
        mem_we        = 1'b0;
        mem_waddr     = {CELL_W'(req_reg.cell_index), idx_reg};
        mem_wdata     = '0;
        mem_raddr     = {CELL_W'(s_req.cell_index),
                         is_query ? LBL_W'(0) : LBL_W'(s_req.voxel_label)};
        alu_ctl.start = 1'b0;
        alu_ctl.step  = 1'b0;
        alu_ctl.vote  = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            rmlv_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = sweep_reg;
            end
            rmlv_pkg::ST_IDLE: begin
                alu_ctl.start = accept && is_query;
            end
            rmlv_pkg::ST_ADD_WR: begin
                mem_we    = ok_reg;
                mem_waddr = {CELL_W'(req_reg.cell_index), LBL_W'(req_reg.voxel_label)};
                mem_wdata = inc_data;
            end
            rmlv_pkg::ST_SCAN: begin
                // read the next label while clearing the current one
                mem_we       = ok_reg;
                mem_raddr    = {CELL_W'(req_reg.cell_index), idx_reg + LBL_W'(1)};
                alu_ctl.step = ok_reg;
                alu_ctl.vote = (idx_reg == '0) || (32'(idx_reg) < 32'(lbl_use));
            end
            rmlv_pkg::ST_DONE: begin
                out_load = out_free;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    // state and sweep counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= rmlv_pkg::ST_CLEAR;
            sweep_reg <= '0;
        end else begin
            state_reg <= state_next;
            if (state_reg == rmlv_pkg::ST_CLEAR) begin
                sweep_reg <= sweep_reg + ADDR_W'(1);
            end
        end
    end

    // request capture and label counter
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_req;
            ok_reg  <= is_query ? cell_ok : (cell_ok && lbl_ok);
            idx_reg <= '0;
        end else if (state_reg == rmlv_pkg::ST_SCAN) begin
            idx_reg <= idx_reg + LBL_W'(1);
        end
    end

endmodule

### hdl/region_majority_label_vote.sv
// Region majority label vote: per-cell label histograms with majority queries.
// Requests arrive on s_valid/s_ready/s_req. An add request (func 0) bumps the
// counter of (cell_index, voxel_label), saturating, by one memory read and one
// write back of the shared incrementer, and gives no result.
// A query request (func 1) scans the cell's NUM_LABELS counters one per cycle
// through the shared compare unit, clearing each as it goes, and loads the
// answer into the m_valid/m_rsp output register once that register is free;
// s_ready returns once the answer is loaded.
// The block holds one request at a time; s_ready drops while it works. An add
// is taken while an answer still waits in the output register; a finished
// query waits for the register to free up when the receiver stalls.
// After aresetn the counter memory is swept to zero, one entry per cycle, over all
// NUM_CELLS * 2**clog2(NUM_LABELS) entries (4096 by default) with s_ready low.
// labels_in_use (APB address 0): write only while idle; the block does not check.
module region_majority_label_vote #(
    parameter int NUM_CELLS  = 256,
    parameter int NUM_LABELS = 16,
    parameter int COUNT_BITS = 24
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rmlv_pkg::req_t       s_req,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rmlv_pkg::rsp_t       m_rsp,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [2:0]           paddr,
    input  logic [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int CELL_W    = $clog2(NUM_CELLS);
    localparam int LBL_W     = $clog2(NUM_LABELS);
    localparam int ADDR_W    = CELL_W + LBL_W;
    localparam int MEM_DEPTH = NUM_CELLS * (1 << LBL_W);

    logic [4:0]            lbl_use_reg;
    logic                  m_valid_reg;
    rmlv_pkg::rsp_t        m_rsp_reg;
    rmlv_pkg::rsp_t        rsp_next;

    logic                  out_free;
    logic                  out_load;
    logic [7:0]            qcell;
    rmlv_pkg::alu_ctl_t    alu_ctl;
    logic [LBL_W-1:0]      alu_idx;
    logic [COUNT_BITS-1:0] inc_data;
    logic [LBL_W-1:0]      best_lbl;
    logic [COUNT_BITS-1:0] best_cnt;
    logic [31:0]           best_wide;
    logic                  empty;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_waddr;
    logic [COUNT_BITS-1:0] mem_wdata;
    logic [ADDR_W-1:0]     mem_raddr;
    logic [COUNT_BITS-1:0] mem_rdata;
    logic                  reg_hit;

    // configuration register
    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == rmlv_pkg::REG_LABELS_IN_USE);
    assign prdata  = reg_hit ? {27'd0, lbl_use_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lbl_use_reg <= rmlv_pkg::LABELS_RESET;
        end else if (psel && penable && pwrite && reg_hit) begin
            lbl_use_reg <= pwdata[4:0];
        end
    end

    rmlv_seq #(
        .NUM_CELLS  (NUM_CELLS),
        .NUM_LABELS (NUM_LABELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_seq (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_req     (s_req),
        .s_ready   (s_ready),
        .lbl_use   (lbl_use_reg),
        .inc_data  (inc_data),
        .out_free  (out_free),
        .out_load  (out_load),
        .qcell     (qcell),
        .alu_ctl   (alu_ctl),
        .alu_idx   (alu_idx),
        .mem_we    (mem_we),
        .mem_waddr (mem_waddr),
        .mem_wdata (mem_wdata),
        .mem_raddr (mem_raddr)
    );

    rmlv_hist_mem #(
        .DEPTH  (MEM_DEPTH),
        .ADDR_W (ADDR_W),
        .DATA_W (COUNT_BITS)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    rmlv_vote_alu #(
        .LBL_W      (LBL_W),
        .COUNT_BITS (COUNT_BITS)
    ) u_alu (
        .aclk     (aclk),
        .ctl      (alu_ctl),
        .idx      (alu_idx),
        .data     (mem_rdata),
        .inc_data (inc_data),
        .best_lbl (best_lbl),
        .best_cnt (best_cnt),
        .empty    (empty)
    );

    // answer assembly with count saturation to the output width
    assign best_wide = 32'(best_cnt);

    always_comb begin
        rsp_next.queried_cell   = qcell;
        rsp_next.majority_label = 4'(best_lbl);
        rsp_next.majority_count = (best_wide > 32'(rmlv_pkg::OUT_COUNT_MAX)) ?
                                  rmlv_pkg::OUT_COUNT_MAX : best_wide[23:0];
        rsp_next.cell_empty     = empty;
    end

    // output register
    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_rsp_reg <= rsp_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;

endmodule

### hdl/rmlv_checker.sv
// port-level checker of the region majority vote block, bound to the top level
`include "region_majority_label_vote_defines.svh"

module rmlv_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input logic           m_valid,
    input logic           m_ready,
    input rmlv_pkg::rsp_t m_rsp
);

    logic zero_count;
    logic zero_label;

    assign zero_count = (m_rsp.majority_count == 24'd0);
    assign zero_label = (m_rsp.majority_label == 4'd0);

    // a stalled answer holds
    `RMLV_ASSERT(a_rsp_hold, m_valid && !m_ready |=> m_valid && $stable(m_rsp), "answer moved")

    // s_ready drops once a request is taken
    `RMLV_ASSERT(a_one_at_a_time, s_valid && s_ready |=> !s_ready, "ready right after a request")

    // an empty cell reports a zero count
    `RMLV_ASSERT(a_empty_count, m_valid && m_rsp.cell_empty |-> zero_count, "empty with count")

    // no votes means label zero
    `RMLV_ASSERT(a_zero_label, m_valid && zero_count |-> zero_label, "label without votes")

endmodule

bind region_majority_label_vote rmlv_checker u_rmlv_checker (.*);
